@@ rtl/core/tfsc_pkg.sv @@
// Shared types and codes for the tick frame sequence checker.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package tfsc_pkg;

    localparam int SEQ_W   = 64;
    localparam int TIME_W  = 64;
    localparam int MAGIC_W = 32;
    localparam int VER_W   = 16;
    localparam int CODE_W  = 16;
    localparam int PHASE_W = 3;
    localparam int STAT_W  = 3;
    localparam int MASK_W  = 3;
    localparam int CFG_W   = 64;
    localparam int IDX_W   = 2;

    // Payload packing of the stream channels, lowest field first.
    // The operation travels on tuser, so it is not part of the input tdata.
    localparam int IN_BITS   = MAGIC_W + VER_W + CODE_W + SEQ_W + TIME_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = STAT_W + SEQ_W + TIME_W + PHASE_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_UPDATE_RATE  = 2'd0,
        REG_PHASE_ENABLE = 2'd1,
        REG_MAGIC        = 2'd2,
        REG_VERSION      = 2'd3
    } reg_idx_t;

    // Operation codes.
    localparam logic OP_RECEIVE  = 1'b0;
    localparam logic OP_COMPLETE = 1'b1;

    // Phase codes.
    localparam logic [CODE_W-1:0] CODE_PREPARE = 16'd1;
    localparam logic [CODE_W-1:0] CODE_EXECUTE = 16'd2;
    localparam logic [CODE_W-1:0] CODE_COMMIT  = 16'd3;
    localparam logic [CODE_W-1:0] CODE_STOP    = 16'd4;
    localparam logic [PHASE_W-1:0] PHASE_NONE  = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_STOP  = 3'd4;

    typedef enum logic [STAT_W-1:0] {
        ST_ACCEPT    = 3'd0,
        ST_STOP      = 3'd1,
        ST_MALFORMED = 3'd2,
        ST_STALE     = 3'd3,
        ST_TIME      = 3'd4,
        ST_REFUSED   = 3'd5
    } status_t;

    // Classification made by the front end.
    typedef enum logic [2:0] {
        KIND_MALFORMED,
        KIND_STOP,
        KIND_FRAME,
        KIND_COMPLETE,
        KIND_REFUSED
    } kind_t;

    typedef struct packed {
        logic [CFG_W-1:0]   update_rate;
        logic [MASK_W-1:0]  phase_en;
        logic [MAGIC_W-1:0] magic;
        logic [VER_W-1:0]   version;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic [PHASE_W-1:0]  phase;
        logic [SEQ_W-1:0]    seq;
        logic [TIME_W-1:0]   tm;
    } item_t;

    typedef struct packed {
        status_t             status;
        logic [SEQ_W-1:0]    seq;
        logic [TIME_W-1:0]   tm;
        logic [PHASE_W-1:0]  phase;
    } result_t;

endpackage

@@ rtl/core/tfsc_front.sv @@
// Front end: unpacks an input transaction and classifies it against the
// stateless checks (magic, version, phase code, enable mask). Uses tfsc_pkg.
module tfsc_front
(
    input  logic                           tuser,
    input  logic [tfsc_pkg::IN_DATA_W-1:0] tdata,
    input  tfsc_pkg::cfg_t                 cfg,
    output tfsc_pkg::item_t                item
);

    logic                          op;
    logic [tfsc_pkg::MAGIC_W-1:0]  magic;
    logic [tfsc_pkg::VER_W-1:0]    version;
    logic [tfsc_pkg::CODE_W-1:0]   code;
    logic                          code_frame_ok;
    logic                          code_work;
    logic                          mask_hit;
    logic [tfsc_pkg::PHASE_W-1:0]  phase;

    assign op      = tuser;
    assign magic   = tdata[31:0];
    assign version = tdata[47:32];
    assign code    = tdata[63:48];

    assign code_frame_ok = (code >= tfsc_pkg::CODE_PREPARE) && (code <= tfsc_pkg::CODE_STOP);
    assign code_work     = (code >= tfsc_pkg::CODE_PREPARE) && (code <= tfsc_pkg::CODE_COMMIT);
    assign phase         = code[tfsc_pkg::PHASE_W-1:0];
    // phase 1..3 maps to mask bit 0..2
    assign mask_hit      = code_work && cfg.phase_en[phase[1:0] - 2'd1];

    always_comb
    begin
        item.phase = phase;
        item.seq   = tdata[127:64];
        item.tm    = tdata[191:128];
        if (op == tfsc_pkg::OP_COMPLETE)
        begin
            item.kind = mask_hit ? tfsc_pkg::KIND_COMPLETE : tfsc_pkg::KIND_REFUSED;
        end
        else if (magic != cfg.magic || version != cfg.version || !code_frame_ok)
        begin
            item.kind = tfsc_pkg::KIND_MALFORMED;
        end
        else if (code == tfsc_pkg::CODE_STOP)
        begin
            item.kind = tfsc_pkg::KIND_STOP;
        end
        else
        begin
            item.kind = tfsc_pkg::KIND_FRAME;
        end
    end

endmodule

@@ rtl/core/tfsc_queue.sv @@
// Two-entry queue of classified items between front and back ends.
// Uses tfsc_pkg for the item type.
module tfsc_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tfsc_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output tfsc_pkg::item_t head
);

    tfsc_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            wr_ptr_next;
    logic            rd_ptr_reg;
    logic            rd_ptr_next;
    logic [1:0]      count_reg;
    logic [1:0]      count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/tfsc_back.sv @@
// Back end: order and time checks against the recorded tick, state update,
// and the output register. Uses tfsc_pkg.
module tfsc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  tfsc_pkg::cfg_t    cfg,
    input  logic              item_valid,
    input  tfsc_pkg::item_t   item,
    output logic              item_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output tfsc_pkg::result_t out_res
);

    logic                          have_last_reg;
    logic                          have_last_next;
    logic [tfsc_pkg::SEQ_W-1:0]    last_seq_reg;
    logic [tfsc_pkg::SEQ_W-1:0]    last_seq_next;
    logic [tfsc_pkg::TIME_W-1:0]   last_time_reg;
    logic [tfsc_pkg::TIME_W-1:0]   last_time_next;
    logic [tfsc_pkg::PHASE_W-1:0]  last_phase_reg;
    logic [tfsc_pkg::PHASE_W-1:0]  last_phase_next;
    logic                          done_reg;
    logic                          done_next;
    logic                          valid_reg;
    logic                          valid_next;
    tfsc_pkg::result_t             res_reg;
    tfsc_pkg::result_t             res_next;

    logic                          seq_lt;
    logic                          seq_eq;
    logic                          seq_succ;
    logic                          time_eq;
    logic                          step_ok;
    logic [tfsc_pkg::TIME_W-1:0]   step;
    tfsc_pkg::result_t             verdict;
    tfsc_pkg::result_t             zero_res;

    assign item_pop  = item_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    assign seq_lt   = item.seq < last_seq_reg;
    assign seq_eq   = item.seq == last_seq_reg;
    assign seq_succ = item.seq == (last_seq_reg + 64'd1);
    assign time_eq  = item.tm == last_time_reg;
    assign step     = item.tm - last_time_reg;
    // time must strictly advance by exactly the update rate
    assign step_ok  = (item.tm > last_time_reg) && (step == cfg.update_rate);

    always_comb
    begin
        zero_res        = '0;
        zero_res.status = tfsc_pkg::ST_REFUSED;

        have_last_next  = have_last_reg;
        last_seq_next   = last_seq_reg;
        last_time_next  = last_time_reg;
        last_phase_next = last_phase_reg;
        done_next       = done_reg;
        verdict         = zero_res;

        unique case (item.kind)
            tfsc_pkg::KIND_MALFORMED:
            begin
                verdict.status = tfsc_pkg::ST_MALFORMED;
            end
            tfsc_pkg::KIND_STOP:
            begin
                verdict.status = tfsc_pkg::ST_STOP;
                verdict.seq    = item.seq;
                verdict.tm     = item.tm;
                verdict.phase  = tfsc_pkg::PHASE_STOP;
            end
            tfsc_pkg::KIND_FRAME:
            begin
                if (have_last_reg && (seq_lt || (seq_eq && item.phase <= last_phase_reg)))
                begin
                    verdict.status = tfsc_pkg::ST_STALE;
                end
                else if (have_last_reg && seq_eq && !time_eq)
                begin
                    verdict.status = tfsc_pkg::ST_TIME;
                end
                else if (have_last_reg && !seq_eq && (!seq_succ || !step_ok))
                begin
                    verdict.status = tfsc_pkg::ST_TIME;
                end
                else
                begin
                    verdict.status  = tfsc_pkg::ST_ACCEPT;
                    verdict.seq     = item.seq;
                    verdict.tm      = item.tm;
                    verdict.phase   = item.phase;
                    have_last_next  = 1'b1;
                    last_seq_next   = item.seq;
                    last_time_next  = item.tm;
                    last_phase_next = item.phase;
                    done_next       = 1'b0;
                end
            end
            tfsc_pkg::KIND_COMPLETE:
            begin
                if (have_last_reg && seq_eq && item.phase == last_phase_reg && !done_reg)
                begin
                    verdict.status = tfsc_pkg::ST_ACCEPT;
                    verdict.seq    = item.seq;
                    verdict.tm     = last_time_reg;
                    verdict.phase  = item.phase;
                    done_next      = 1'b1;
                end
            end
            tfsc_pkg::KIND_REFUSED:
            begin
                verdict = zero_res;
            end
            default:
            begin
                verdict = zero_res;
            end
        endcase

        if (!item_pop)
        begin
            have_last_next  = have_last_reg;
            last_seq_next   = last_seq_reg;
            last_time_next  = last_time_reg;
            last_phase_next = last_phase_reg;
            done_next       = done_reg;
        end

        valid_next = item_pop ? 1'b1 : (valid_reg && !out_ready);
        res_next   = item_pop ? verdict : res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_last_reg  <= 1'b0;
            last_seq_reg   <= '0;
            last_time_reg  <= '0;
            last_phase_reg <= tfsc_pkg::PHASE_NONE;
            done_reg       <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            have_last_reg  <= have_last_next;
            last_seq_reg   <= last_seq_next;
            last_time_reg  <= last_time_next;
            last_phase_reg <= last_phase_next;
            done_reg       <= done_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

@@ rtl/core/tick_frame_sequence_checker_unit.sv @@
// Top level of the tick frame sequence checker: configuration registers,
// front end, item queue and back end. Uses tfsc_pkg, tfsc_front, tfsc_queue, tfsc_back.
//
// Usage
//   Input stream (s_t*): one transaction is a receive-frame or complete-phase
//   request, the operation on s_tuser. Output stream (m_t*): exactly one
//   result transaction per input, in input order. Configuration:
//   wr_en/wr_index/wr_data; the user must write it only while no transaction is
//   in flight, which the block does not enforce; a phase mask write of zero is ignored.
//   Path: an accepted transaction goes from the front end into the queue, and the back
//   end moves it into the output register, from which it can leave. Throughput: one
//   transaction per cycle while m_tready is high, set by the back end, which checks
//   and updates the recorded tick in the same step.
//   Output stalls: the output register holds its result while m_tready is
//   low; the two-entry queue keeps taking input until it fills, then
//   s_tready drops. Nothing is lost or repeated.
//   Reset: registers return to update_rate 1, mask commit only, magic and
//   version 0; no tick is recorded and both streams are empty.
module tick_frame_sequence_checker_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             wr_en,
    input  logic [tfsc_pkg::IDX_W-1:0]       wr_index,
    input  logic [tfsc_pkg::CFG_W-1:0]       wr_data,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tuser: operation[0]
    input  logic                             s_tuser,
    // tdata: frame_magic[31:0], frame_version[47:32], phase_code[63:48],
    //        tick_sequence[127:64], tick_time[191:128]
    input  logic [tfsc_pkg::IN_DATA_W-1:0]   s_tdata,
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: status[2:0], out_sequence[66:3], out_time[130:67],
    //        out_phase[133:131], pad
    output logic [tfsc_pkg::OUT_DATA_W-1:0]  m_tdata
);

    tfsc_pkg::cfg_t    cfg_reg;
    tfsc_pkg::cfg_t    cfg_next;
    tfsc_pkg::item_t   front_item;
    tfsc_pkg::item_t   head_item;
    tfsc_pkg::result_t res;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic              push;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (tfsc_pkg::reg_idx_t'(wr_index))
                tfsc_pkg::REG_UPDATE_RATE: cfg_next.update_rate = wr_data;
                tfsc_pkg::REG_PHASE_ENABLE:
                begin
                    if (wr_data[tfsc_pkg::MASK_W-1:0] != '0)
                    begin
                        cfg_next.phase_en = wr_data[tfsc_pkg::MASK_W-1:0];
                    end
                end
                tfsc_pkg::REG_MAGIC:       cfg_next.magic   = wr_data[tfsc_pkg::MAGIC_W-1:0];
                tfsc_pkg::REG_VERSION:     cfg_next.version = wr_data[tfsc_pkg::VER_W-1:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.update_rate <= 64'd1;
            cfg_reg.phase_en    <= 3'b100;
            cfg_reg.magic       <= '0;
            cfg_reg.version     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: classify and push into the queue
    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;

    tfsc_front u_front
    (
        .tuser (s_tuser),
        .tdata (s_tdata),
        .cfg   (cfg_reg),
        .item  (front_item)
    );

    tfsc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_item)
    );

    // Back end: stateful checks and the output register
    tfsc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_not_empty),
        .item       (head_item),
        .item_pop   (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    assign m_tdata = {{(tfsc_pkg::OUT_DATA_W - tfsc_pkg::OUT_BITS){1'b0}},
                      res.phase, res.tm, res.seq, res.status};

`ifndef SYNTHESIS
    // A stop result always carries the stop phase.
    a_stop_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.status == tfsc_pkg::ST_STOP) |-> (res.phase == tfsc_pkg::PHASE_STOP))
        else $error("stop result without stop phase");

    // Rejections carry no sequence, time or phase.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (res.status == tfsc_pkg::ST_MALFORMED || res.status == tfsc_pkg::ST_STALE ||
                      res.status == tfsc_pkg::ST_TIME || res.status == tfsc_pkg::ST_REFUSED))
        |-> (res.seq == '0 && res.tm == '0 && res.phase == tfsc_pkg::PHASE_NONE))
        else $error("rejected result with nonzero payload");

    // The back end never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("queue popped while empty");

    // An accepted result shows a phase between prepare and commit.
    a_accept_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res.status == tfsc_pkg::ST_ACCEPT)
        |-> (res.phase != tfsc_pkg::PHASE_NONE && res.phase != tfsc_pkg::PHASE_STOP))
        else $error("accepted result with bad phase");
`endif

endmodule
